FILE: sv/bdeq_pkg.sv
// bdeq_pkg: shared types and constants for the bounded double-ended queue
// holds operation and status codes and the per-row control struct of the cell chain
// no dependencies
package bdeq_pkg;

  // operation codes carried by an input beat
  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  // status codes carried by a result beat
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_t;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 5;

  // value shown for front and back when nothing is held
  localparam logic signed [DATA_W-1:0] EMPTY_READ = -32'sd1;

  // control for one row of the chain, one hot or all low
  typedef struct packed {
    logic shr;  // shift towards the far end, new entry at cell 0
    logic shl;  // shift towards cell 0, cell 0 entry dropped
    logic wr;   // write the push value into the cell at the fill level
  } chain_ctl_t;

endpackage

FILE: sv/bounded_double_ended_queue_unit.sv
// Bounded double-ended queue of DEPTH signed 32-bit entries. One operation
// (push back, push front, pop front, pop back) is taken per cycle: busy stays
// low, so a start beat is accepted at every edge where start is high. Each
// accepted beat gives exactly one result beat on the next cycle, marked by
// out_valid for one cycle; the result must be captured then. The store is a
// chain of DEPTH cells with two rows, one ordered from the front and one
// from the back, so every operation is a row shift, a local write or both,
// and front and back are always at cell 0. No clearing pass after reset.
// A push on full or a pop on empty leaves the queue as it is and is flagged.
// depends on bdeq_pkg and bdeq_cell
module bounded_double_ended_queue_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_op,
  input  logic signed [31:0]                 in_value,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic [4:0]                         out_count,
  output logic                               out_is_empty,
  output logic signed [31:0]                 out_front_value,
  output logic signed [31:0]                 out_back_value
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]           count_r;
  logic [CNT_W-1:0]           count_nxt;
  logic                       full;
  logic                       empty;
  bdeq_pkg::op_t              op;
  bdeq_pkg::status_t          status_nxt;
  bdeq_pkg::chain_ctl_t       a_ctl;
  bdeq_pkg::chain_ctl_t       b_ctl;

  logic signed [31:0]         a_q [DEPTH];
  logic signed [31:0]         b_q [DEPTH];
  logic signed [31:0]         front_nxt;
  logic signed [31:0]         back_nxt;

  logic                       out_valid_r;
  bdeq_pkg::status_t          status_r;
  logic [4:0]                 out_count_r;
  logic                       is_empty_r;
  logic signed [31:0]         front_r;
  logic signed [31:0]         back_r;

  assign busy  = 1'b0;
  assign op    = bdeq_pkg::op_t'(in_op);
  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  // operation decode into row controls
  always_comb begin
    a_ctl      = '0;
    b_ctl      = '0;
    count_nxt  = count_r;
    status_nxt = bdeq_pkg::ST_DONE;
    if (start) begin
      unique case (op)
        bdeq_pkg::OP_PUSH_BACK: begin
          if (full) begin
            status_nxt = bdeq_pkg::ST_PUSH_FULL;
          end else begin
            a_ctl.wr  = 1'b1;
            b_ctl.shr = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        bdeq_pkg::OP_PUSH_FRONT: begin
          if (full) begin
            status_nxt = bdeq_pkg::ST_PUSH_FULL;
          end else begin
            a_ctl.shr = 1'b1;
            b_ctl.wr  = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        bdeq_pkg::OP_POP_FRONT: begin
          if (empty) begin
            status_nxt = bdeq_pkg::ST_POP_EMPTY;
          end else begin
            a_ctl.shl = 1'b1;
            count_nxt = count_r - 1'b1;
          end
        end
        bdeq_pkg::OP_POP_BACK: begin
          if (empty) begin
            status_nxt = bdeq_pkg::ST_POP_EMPTY;
          end else begin
            b_ctl.shl = 1'b1;
            count_nxt = count_r - 1'b1;
          end
        end
        default: begin
          status_nxt = bdeq_pkg::ST_DONE;
        end
      endcase
    end
  end

  // the cell chain
  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
        bdeq_cell #(.IDX(i), .CNT_W(CNT_W)) u_cell (
          .clk     (clk),
          .a_ctl   (a_ctl),
          .b_ctl   (b_ctl),
          .count   (count_r),
          .ins     (in_value),
          .a_left  (in_value),
          .a_right (a_q[1]),
          .b_left  (in_value),
          .b_right (b_q[1]),
          .a_q     (a_q[0]),
          .b_q     (b_q[0]),
          .a_nxt   (front_nxt),
          .b_nxt   (back_nxt)
        );
      end else if (i == DEPTH - 1) begin : g_tail
        bdeq_cell #(.IDX(i), .CNT_W(CNT_W)) u_cell (
          .clk     (clk),
          .a_ctl   (a_ctl),
          .b_ctl   (b_ctl),
          .count   (count_r),
          .ins     (in_value),
          .a_left  (a_q[i-1]),
          .a_right (a_q[i]),
          .b_left  (b_q[i-1]),
          .b_right (b_q[i]),
          .a_q     (a_q[i]),
          .b_q     (b_q[i]),
          .a_nxt   (),
          .b_nxt   ()
        );
      end else begin : g_mid
        bdeq_cell #(.IDX(i), .CNT_W(CNT_W)) u_cell (
          .clk     (clk),
          .a_ctl   (a_ctl),
          .b_ctl   (b_ctl),
          .count   (count_r),
          .ins     (in_value),
          .a_left  (a_q[i-1]),
          .a_right (a_q[i+1]),
          .b_left  (b_q[i-1]),
          .b_right (b_q[i+1]),
          .a_q     (a_q[i]),
          .b_q     (b_q[i]),
          .a_nxt   (),
          .b_nxt   ()
        );
      end
    end
  endgenerate

  // fill level and result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= start;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    status_r    <= status_nxt;
    out_count_r <= 5'(count_nxt);
    is_empty_r  <= (count_nxt == '0);
    front_r     <= (count_nxt == '0) ? bdeq_pkg::EMPTY_READ : front_nxt;
    back_r      <= (count_nxt == '0) ? bdeq_pkg::EMPTY_READ : back_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_count       = out_count_r;
  assign out_is_empty    = is_empty_r;
  assign out_front_value = front_r;
  assign out_back_value  = back_r;

endmodule

FILE: sv/bdeq_cell.sv
// bdeq_cell: one cell of the deque chain, holding one entry of each row
// row a keeps the front at cell 0, row b keeps the back at cell 0
// depends on bdeq_pkg
module bdeq_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic                                 clk,
  input  bdeq_pkg::chain_ctl_t                 a_ctl,
  input  bdeq_pkg::chain_ctl_t                 b_ctl,
  input  logic [CNT_W-1:0]                     count,
  input  logic signed [bdeq_pkg::DATA_W-1:0]   ins,
  input  logic signed [bdeq_pkg::DATA_W-1:0]   a_left,
  input  logic signed [bdeq_pkg::DATA_W-1:0]   a_right,
  input  logic signed [bdeq_pkg::DATA_W-1:0]   b_left,
  input  logic signed [bdeq_pkg::DATA_W-1:0]   b_right,
  output logic signed [bdeq_pkg::DATA_W-1:0]   a_q,
  output logic signed [bdeq_pkg::DATA_W-1:0]   b_q,
  output logic signed [bdeq_pkg::DATA_W-1:0]   a_nxt,
  output logic signed [bdeq_pkg::DATA_W-1:0]   b_nxt
);

  logic signed [bdeq_pkg::DATA_W-1:0] a_r;
  logic signed [bdeq_pkg::DATA_W-1:0] b_r;
  logic                               at_fill;

  // this cell sits just past the last held entry
  assign at_fill = (count == CNT_W'(IDX));

  // row a next value
  always_comb begin
    priority if (a_ctl.shr) begin
      a_nxt = a_left;
    end else if (a_ctl.shl) begin
      a_nxt = a_right;
    end else if (a_ctl.wr && at_fill) begin
      a_nxt = ins;
    end else begin
      a_nxt = a_r;
    end
  end

  // row b next value
  always_comb begin
    priority if (b_ctl.shr) begin
      b_nxt = b_left;
    end else if (b_ctl.shl) begin
      b_nxt = b_right;
    end else if (b_ctl.wr && at_fill) begin
      b_nxt = ins;
    end else begin
      b_nxt = b_r;
    end
  end

  // entry storage, no reset needed
  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  assign a_q = a_r;
  assign b_q = b_r;

endmodule

FILE: sv/bdeq_checker.sv
// bdeq_checker: port-level checks on the deque, attached by bind
// depends on bounded_double_ended_queue_unit ports and bdeq_pkg
module bdeq_checker #(
  parameter int unsigned DEPTH = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic [1:0]         out_status,
  input logic [4:0]         out_count,
  input logic               out_is_empty,
  input logic signed [31:0] out_front_value,
  input logic signed [31:0] out_back_value
);

  // every accepted beat gives a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("no result after accepted beat");

  // no result without an accepted beat
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without accepted beat");

  // empty queue reads as minus one on both ends
  a_empty_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |->
      (out_front_value == bdeq_pkg::EMPTY_READ && out_back_value == bdeq_pkg::EMPTY_READ))
    else $error("empty queue shows a value");

  // a refused pop only happens on an empty queue
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == bdeq_pkg::ST_POP_EMPTY) |-> (out_is_empty && out_count == '0))
    else $error("pop refused on non-empty queue");

  // empty flag agrees with the count while the count is not masked
  a_flag_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && DEPTH < 32) |-> (out_is_empty == (out_count == '0)))
    else $error("empty flag disagrees with count");

endmodule

bind bounded_double_ended_queue_unit bdeq_checker #(.DEPTH(DEPTH)) u_bdeq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_count       (out_count),
  .out_is_empty    (out_is_empty),
  .out_front_value (out_front_value),
  .out_back_value  (out_back_value)
);
